/* design/lcddc_pkg.sv */
// Shared constants, types and the digit split for the LCD decimal counter writer.
package lcddc_pkg;

  // Field and state widths.
  localparam int CNT_W   = 20;
  localparam int VAL_W   = 8;
  localparam int NIB_W   = 4;
  localparam int SLOT_W  = 3;

  // Reset values of the period register and the shown value.
  localparam logic [CNT_W-1:0] PERIOD_RESET = 20'd1000000;
  localparam logic [VAL_W-1:0] VALUE_RESET  = 8'd1;

  // Nibbles sent on the LCD data lines.
  localparam logic [NIB_W-1:0] NIB_CLEAR_HI = 4'h0;
  localparam logic [NIB_W-1:0] NIB_CLEAR_LO = 4'h1;
  localparam logic [NIB_W-1:0] NIB_ASCII_HI = 4'h3;

  // Slots of one display update, in transmit order.
  localparam logic [SLOT_W-1:0] SLOT_CLEAR_HI = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_CLEAR_LO = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_HUND_HI  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_HUND     = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_TENS_HI  = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_TENS     = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_UNITS_HI = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_UNITS    = 3'd7;

  // Decimal digits of one value.
  typedef struct packed {
    logic [NIB_W-1:0] hund;
    logic [NIB_W-1:0] tens;
    logic [NIB_W-1:0] units;
  } digits_t;

  // Request from the counter to the burst sequencer.
  typedef struct packed {
    logic    load;
    digits_t digits;
  } burst_req_t;

  // Split an 8-bit value into hundreds, tens and units.
  // Tens use the reciprocal 205/2048, exact for remainders below 100.
  function automatic digits_t to_digits(input logic [VAL_W-1:0] v);
    digits_t     d;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [6:0]  tens_x10;
    if (v >= 8'd200) begin
      d.hund = 4'd2;
      rem    = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      d.hund = 4'd1;
      rem    = 7'(v - 8'd100);
    end else begin
      d.hund = 4'd0;
      rem    = v[6:0];
    end
    prod     = {8'd0, rem} * 15'd205;
    d.tens   = prod[14:11];
    tens_x10 = 7'({3'd0, d.tens} * 7'd10);
    d.units  = 4'(rem - tens_x10);
    return d;
  endfunction

endpackage

/* design/lcddc_if.sv */
// Valid/ready channel interfaces for tick input and LCD nibble output.
interface lcddc_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface lcddc_nibble_if;
  logic                         valid;
  logic                         ready;
  logic [lcddc_pkg::NIB_W-1:0]  nibble;
  logic                         reg_select;
  logic                         last;

  modport source (output valid, output nibble, output reg_select, output last, input ready);
  modport sink   (input valid, input nibble, input reg_select, input last, output ready);
endinterface

/* design/lcddc_burst.sv */
// Burst sequencer: turns one display update into eight registered nibble transactions.
module lcddc_burst (
  input  logic                  clk,
  input  logic                  rst,
  input  lcddc_pkg::burst_req_t req,
  output logic                  active,
  lcddc_nibble_if.source        out_ch
);

  logic [lcddc_pkg::SLOT_W-1:0] slot;
  lcddc_pkg::digits_t           digits;
  logic                         advance;
  logic [lcddc_pkg::NIB_W-1:0]  nib_next;
  logic                         rs_next;

  // The output register takes a new nibble when it is empty or being drained.
  assign advance = active && (!out_ch.valid || out_ch.ready);

  // Nibble and RS line for the current slot.
  always_comb begin
    case (slot)
      lcddc_pkg::SLOT_CLEAR_HI: begin
        nib_next = lcddc_pkg::NIB_CLEAR_HI;
        rs_next  = 1'b0;
      end
      lcddc_pkg::SLOT_CLEAR_LO: begin
        nib_next = lcddc_pkg::NIB_CLEAR_LO;
        rs_next  = 1'b0;
      end
      lcddc_pkg::SLOT_HUND_HI, lcddc_pkg::SLOT_TENS_HI, lcddc_pkg::SLOT_UNITS_HI: begin
        nib_next = lcddc_pkg::NIB_ASCII_HI;
        rs_next  = 1'b1;
      end
      lcddc_pkg::SLOT_HUND: begin
        nib_next = digits.hund;
        rs_next  = 1'b1;
      end
      lcddc_pkg::SLOT_TENS: begin
        nib_next = digits.tens;
        rs_next  = 1'b1;
      end
      lcddc_pkg::SLOT_UNITS: begin
        nib_next = digits.units;
        rs_next  = 1'b1;
      end
      default: begin
        nib_next = lcddc_pkg::NIB_ASCII_HI;
        rs_next  = 1'b1;
      end
    endcase
  end

  // Sequencer control: a load starts at the clear command and runs to the units digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      slot   <= lcddc_pkg::SLOT_CLEAR_HI;
    end else if (req.load) begin
      active <= 1'b1;
      slot   <= lcddc_pkg::SLOT_CLEAR_HI;
    end else if (advance) begin
      slot <= slot + 3'd1;
      if (slot == lcddc_pkg::SLOT_UNITS) begin
        active <= 1'b0;
      end
    end
  end

  // Digits of the value being shown.
  always_ff @(posedge clk) begin
    if (req.load) begin
      digits <= req.digits;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.nibble     <= nib_next;
      out_ch.reg_select <= rs_next;
      out_ch.last       <= (slot == lcddc_pkg::SLOT_UNITS);
    end
  end

endmodule

/* design/lcd_decimal_counter_writer_unit.sv */
// Top level of the LCD decimal counter writer: tick counter, shown value and burst output.
//
// Usage: each transaction on in_ch carries one tick bit. A tick of 1 advances a
// 20-bit counter; when the counter equals tick_period at that tick, the block
// sends one display update for the shown value and then increments the value
// (wrapping at 256), and the counter restarts. An update is eight transactions
// on out_ch: the clear command (nibbles 0 and 1, RS low), then for hundreds,
// tens and units the nibble 3 followed by the digit, RS high; last marks the
// units digit. tick_period is written through cfg_write_en/cfg_write_data.
// Throughput: one input transaction per cycle. The only stall is an input
// transaction that arrives while the counter equals tick_period and the previous
// update's eight nibbles are still being handed to the output register; the
// eight-slot burst sequencer sets this.
// The tick that starts an update loads the sequencer registers, and from them
// the output register takes the first nibble; the rest follow one per cycle
// while out_ch.ready is high. When the receiver stalls, the output register
// holds its nibble and the sequencer waits; input transactions are still taken
// unless the counter equals tick_period while the sequencer is busy.
// Reset: the counter clears, the shown value becomes 1, the period returns to
// 1000000, and out_ch is empty. No clearing pass is needed.
module lcd_decimal_counter_writer_unit (
  input  logic                         clk,
  input  logic                         rst,
  lcddc_tick_if.sink                   in_ch,
  lcddc_nibble_if.source               out_ch,
  input  logic                         cfg_write_en,
  input  logic [lcddc_pkg::CNT_W-1:0]  cfg_write_data
);

  logic [lcddc_pkg::CNT_W-1:0] tick_period;
  logic [lcddc_pkg::CNT_W-1:0] tick_count;
  logic [lcddc_pkg::VAL_W-1:0] shown_value;
  logic                        busy;
  logic                        match;
  logic                        take_tick;
  lcddc_pkg::burst_req_t       req;

  // A tick that would start an update must wait for a free sequencer.
  assign match       = (tick_count == tick_period);
  assign in_ch.ready = !busy || !match;
  assign take_tick   = in_ch.valid && in_ch.ready && in_ch.tick;

  assign req.load   = take_tick && match;
  assign req.digits = lcddc_pkg::to_digits(shown_value);

  // Period register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= lcddc_pkg::PERIOD_RESET;
    end else if (cfg_write_en) begin
      tick_period <= cfg_write_data;
    end
  end

  // Tick counter and shown value.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      shown_value <= lcddc_pkg::VALUE_RESET;
    end else if (take_tick) begin
      if (match) begin
        tick_count  <= 20'd1;
        shown_value <= shown_value + 8'd1;
      end else begin
        tick_count <= tick_count + 20'd1;
      end
    end
  end

  lcddc_burst u_burst (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .active (busy),
    .out_ch (out_ch)
  );

endmodule

/* design/lcddc_checker.sv */
// Port-level checker for the LCD decimal counter writer, bound to the top level.
module lcddc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lcddc_pkg::NIB_W-1:0] out_nibble,
  input logic                        out_reg_select,
  input logic                        out_last
);

  // A stalled nibble transaction holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_nibble) &&
      $stable(out_reg_select) && $stable(out_last))
    else $error("stalled nibble transaction changed");

  // After reset the output is empty and the input is open.
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output not empty or input not ready after reset");

  // Within one update the nibbles follow back to back.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a display update");

  // After the last nibble the output is empty or a new update begins with the clear command.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=>
      !out_valid || (out_nibble == lcddc_pkg::NIB_CLEAR_HI && !out_reg_select))
    else $error("last nibble not followed by an empty cycle or a new update");

  // A valid nibble after an empty cycle begins an update with the clear command.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> out_nibble == lcddc_pkg::NIB_CLEAR_HI && !out_reg_select)
    else $error("update did not start with the clear command");

endmodule

bind lcd_decimal_counter_writer_unit lcddc_checker u_lcddc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_nibble     (out_ch.nibble),
  .out_reg_select (out_ch.reg_select),
  .out_last       (out_ch.last)
);
